### src/unordered_keyed_record_table_assert.svh
// Assertion macros shared by the record table RTL.
`ifndef UNORDERED_KEYED_RECORD_TABLE_ASSERT_SVH
`define UNORDERED_KEYED_RECORD_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define UKRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define UKRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ukrt_pkg.sv
`default_nettype none

package ukrt_pkg;

  localparam int DEPTH        = 32;
  localparam int PAYLOAD_BITS = 64;
  localparam int KEY_BITS     = 32;
  localparam int IN_PL_BITS   = 64;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int POS_W        = 5;
  localparam int COUNT_W      = 6;
  localparam int STATUS_W     = 2;
  localparam int OP_W         = 2;
  localparam int ENTRY_W      = KEY_BITS + PAYLOAD_BITS;
  localparam int IN_DATA_W    = 96;
  localparam int OUT_DATA_W   = 80;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  localparam logic MODE_MOVE_LAST = 1'b0;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

endpackage

`default_nettype wire

### src/ukrt_ram.sv
`default_nettype none

module ukrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/unordered_keyed_record_table.sv
// Channel  Direction  Contents
// in_      request    tuser: op; tdata: key, payload
// out_     result     tuser: status; tdata: position, found_payload, count
// cfg_     write      wr_data: removal_mode
//
// One request is handled at a time; in_tready is low from acceptance until the
// result is taken. Insert and unused ops finish without a scan; a lookup or remove scans
// the entries in order until the key matches or the count is reached. Removal then either
// moves the last entry into the hole or shifts later entries down one place. The
// single read port of the entry RAM reads one entry per cycle during the scan.
// Reset clears only the control state; RAM data beyond the count is never used.
`default_nettype none
`include "unordered_keyed_record_table_assert.svh"

module unordered_keyed_record_table (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ukrt_pkg::IN_DATA_W-1:0]     in_tdata,   // key, payload
  input  wire logic [ukrt_pkg::OP_W-1:0]          in_tuser,   // op
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [ukrt_pkg::OUT_DATA_W-1:0]    out_tdata,  // position, found_payload, count, zeros
  output logic      [ukrt_pkg::STATUS_W-1:0]      out_tuser,  // status
  input  wire logic                               cfg_wr_en,
  input  wire logic                               cfg_wr_data
);

  import ukrt_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_MOVE_RD = 3'd2;
  localparam logic [2:0] S_MOVE_WR = 3'd3;
  localparam logic [2:0] S_SHIFT   = 3'd4;
  localparam logic [2:0] S_OUT     = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  cmp_v_r, cmp_v_nxt;
  logic                  mode_r;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [IDX_W-1:0]      hole_r, hole_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [IN_PL_BITS-1:0] found_r, found_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [IDX_W-1:0]      ram_raddr;
  entry_t                ram_wdata;
  entry_t                ram_rdata;
  logic [ENTRY_W-1:0]    ram_rdata_raw;

  logic [CNT_W-1:0]      prev_idx;
  logic [CNT_W-1:0]      shift_dst;
  logic [CNT_W-1:0]      last_idx;
  logic [KEY_BITS-1:0]   in_key;
  logic [IN_PL_BITS-1:0] in_payload;

  assign ram_rdata  = entry_t'(ram_rdata_raw);
  assign prev_idx   = idx_r - CNT_W'(1);
  assign shift_dst  = idx_r - CNT_W'(2);
  assign last_idx   = count_r - CNT_W'(1);
  assign in_key     = in_tdata[KEY_BITS-1:0];
  assign in_payload = in_tdata[KEY_BITS +: IN_PL_BITS];

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    cmp_v_nxt  = cmp_v_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    hole_nxt   = hole_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    ram_we     = 1'b0;
    ram_waddr  = count_r[IDX_W-1:0];
    ram_wdata  = '{key: in_key, payload: in_payload[PAYLOAD_BITS-1:0]};
    ram_raddr  = idx_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          key_nxt    = in_key;
          status_nxt = ST_OK;
          pos_nxt    = '0;
          found_nxt  = '0;
          idx_nxt    = '0;
          cmp_v_nxt  = 1'b0;
          if (in_tuser == OP_INSERT) begin
            if (count_r < CNT_W'(DEPTH)) begin
              ram_we    = 1'b1;
              pos_nxt   = POS_W'(count_r);
              count_nxt = count_r + CNT_W'(1);
            end else begin
              status_nxt = ST_FULL;
            end
            state_nxt = S_OUT;
          end else if (in_tuser == OP_LOOKUP || in_tuser == OP_REMOVE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (cmp_v_r && ram_rdata.key == key_r) begin
          pos_nxt   = POS_W'(prev_idx);
          found_nxt = IN_PL_BITS'(ram_rdata.payload);
          hole_nxt  = prev_idx[IDX_W-1:0];
          cmp_v_nxt = 1'b0;
          if (op_r == OP_LOOKUP) begin
            state_nxt = S_OUT;
          end else if (mode_r == MODE_MOVE_LAST) begin
            state_nxt = S_MOVE_RD;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (idx_r < count_r) begin
          idx_nxt   = idx_r + CNT_W'(1);
          cmp_v_nxt = 1'b1;
        end else begin
          status_nxt = ST_MISSING;
          state_nxt  = S_OUT;
        end
      end
      S_MOVE_RD: begin
        ram_raddr = last_idx[IDX_W-1:0];
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = hole_r;
        ram_wdata = ram_rdata;
        count_nxt = last_idx;
        state_nxt = S_OUT;
      end
      S_SHIFT: begin
        // Entry idx_r - 1 arrives from the RAM and lands one place lower.
        ram_waddr = shift_dst[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_we    = cmp_v_r;
        if (idx_r < count_r) begin
          idx_nxt   = idx_r + CNT_W'(1);
          cmp_v_nxt = 1'b1;
        end else begin
          cmp_v_nxt = 1'b0;
          count_nxt = last_idx;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      cmp_v_r <= 1'b0;
      mode_r  <= MODE_MOVE_LAST;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      cmp_v_r <= cmp_v_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    hole_r   <= hole_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
    found_r  <= found_nxt;
  end

  ukrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = status_r;
  assign out_tdata  = {(OUT_DATA_W - POS_W - IN_PL_BITS - COUNT_W)'(0),
                       COUNT_W'(count_r), found_r, pos_r};

  `UKRT_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `UKRT_ASSERT_IMP(a_busy_excl, out_tvalid, !in_tready, "ready while a result is pending")
  `UKRT_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, !in_tready, "ready after accept")
  `UKRT_ASSERT_NXT(a_done_idle, out_tvalid && out_tready, in_tready, "not idle after result")

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ukrt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic MODE_SHIFT_DOWN = 1'b1;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        position;
    logic [PAYLOAD_BITS-1:0] found_payload;
    logic [COUNT_W-1:0]      count;
  } table_result_t;

  class record_table_scoreboard;
    logic [KEY_BITS-1:0]     keys [DEPTH];
    logic [PAYLOAD_BITS-1:0] payloads [DEPTH];
    int unsigned             entries;
    logic                    removal_mode;
    table_result_t           pending_results[$];
    int                      errors;

    function new();
      entries = 0;
      removal_mode = MODE_MOVE_LAST;
      errors = 0;
    endfunction

    function void set_mode(logic mode);
      removal_mode = mode;
    endfunction

    function int find_first(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < entries; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
                               logic [PAYLOAD_BITS-1:0] payload);
      table_result_t r;
      int hit;
      int unsigned last;
      r.status = ST_OK;
      r.position = '0;
      r.found_payload = '0;
      case (op)
        OP_INSERT: begin
          if (entries < DEPTH) begin
            keys[entries] = key;
            payloads[entries] = payload;
            r.position = POS_W'(entries);
            entries++;
          end else begin
            r.status = ST_FULL;
          end
        end
        OP_LOOKUP, OP_REMOVE: begin
          hit = find_first(key);
          if (hit < 0) begin
            r.status = ST_MISSING;
          end else begin
            r.position = POS_W'(hit);
            r.found_payload = payloads[hit];
            if (op == OP_REMOVE) begin
              last = entries - 1;
              if (removal_mode == MODE_MOVE_LAST) begin
                keys[hit] = keys[last];
                payloads[hit] = payloads[last];
              end else begin
                for (int j = hit; j < last; j++) begin
                  keys[j] = keys[j + 1];
                  payloads[j] = payloads[j + 1];
                end
              end
              entries = last;
            end
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(entries);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position,
                               logic [PAYLOAD_BITS-1:0] found_payload,
                               logic [COUNT_W-1:0] count);
      table_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d position %0d",
                 $time, status, position);
        $display("%0t: unexpected result payload %h count %0d",
                 $time, found_payload, count);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 64'(want.status), 64'(status));
      compare_field("position", 64'(want.position), 64'(position));
      compare_field("found_payload", 64'(want.found_payload), 64'(found_payload));
      compare_field("count", 64'(want.count), 64'(count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  record_table_scoreboard sb = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_cycles = 0;

  always #5 clk = ~clk;

  unordered_keyed_record_table i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  task automatic send_request(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
                              logic [PAYLOAD_BITS-1:0] payload);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {payload, key};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, key, payload);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic mode);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_mode(mode);
    @(posedge clk);
  endtask

  // Lookups and removes mostly target keys that are present, and inserts draw from a
  // small key pool so that duplicates are common.
  task automatic random_request(int insert_pct);
    logic [OP_W-1:0] op;
    logic [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0] payload;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) op = OP_UNUSED;
    else if (pick < insert_pct) op = OP_INSERT;
    else if (pick % 2 == 0) op = OP_LOOKUP;
    else op = OP_REMOVE;
    payload = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (op != OP_INSERT && sb.entries != 0 && pick < 7)
      key = sb.keys[$urandom_range(0, sb.entries - 1)];
    else if (pick < 9) key = $urandom_range(0, 23);
    else key = $urandom;
    send_request(op, key, payload);
  endtask

  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      int gap;
      gap = rx_idle ? $urandom_range(0, 14) : 0;
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tuser, out_tdata[4:0], out_tdata[68:5], out_tdata[74:69]);
    end
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("** unordered_keyed_record_table: FAILED **");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(MODE_MOVE_LAST);

    // The empty table, duplicates, and a match at entry 0 in both removal modes.
    send_request(OP_LOOKUP, 32'd0, 64'd0);
    send_request(OP_REMOVE, 32'd0, 64'd0);
    send_request(OP_UNUSED, 32'd0, 64'd0);
    send_request(OP_INSERT, 32'd0, 64'd0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_INSERT, 32'd5, 64'hA5A5_5A5A_0F0F_F0F0);
    send_request(OP_INSERT, 32'd0, 64'h1234);
    send_request(OP_INSERT, 32'd7, 64'h8000_0000_0000_0001);
    send_request(OP_LOOKUP, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 64'd0);
    send_request(OP_LOOKUP, 32'd12345, 64'd0);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_REMOVE, 32'd0, 64'd0);
    send_request(OP_LOOKUP, 32'd0, 64'd0);
    write_mode(MODE_SHIFT_DOWN);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 64'd0);
    send_request(OP_LOOKUP, 32'd0, 64'd0);
    send_request(OP_REMOVE, 32'd7, 64'd0);
    send_request(OP_REMOVE, 32'd0, 64'd0);
    send_request(OP_REMOVE, 32'd5, 64'd0);
    send_request(OP_LOOKUP, 32'd5, 64'd0);

    // Insert-heavy phases fill the table, the others drain it, in both modes.
    for (int phase = 0; phase < 8; phase++) begin
      write_mode(phase % 2 == 1 ? MODE_SHIFT_DOWN : MODE_MOVE_LAST);
      tx_idle = (phase != 5);
      rx_idle = (phase != 5);
      if (phase == 3) rx_hold_cycles = 400;
      for (int n = 0; n < 150; n++) begin
        if (phase == 6 && n == 75) drain_results();
        random_request((phase % 4) < 2 ? 75 : 25);
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("** unordered_keyed_record_table: PASSED **");
    end else begin
      if (sb.pending_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
      $display("** unordered_keyed_record_table: FAILED **");
    end
    $finish;
  end

endmodule
